[hw/rtl/arpc_pkg.sv]
// ----------------------------------------------------------------------------
// arpc_pkg
// shared types and constants of the address resolution cache
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int IDX_W = 10;
  localparam int CNT_W = 11;
  localparam int KEY_W = 32;
  localparam int MAC_W = 48;
  localparam int PORT_W = 4;
  localparam int DL_W = 32;
  localparam logic [DL_W-1:0] DL_MAX = '1;
  localparam logic [31:0] MAX_AGE_RST = 32'd1200000;

  typedef enum logic [2:0] {
    MODE_LOOKUP = 3'd0,
    MODE_UPDATE = 3'd1,
    MODE_ADD    = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_SETEXP = 3'd4,
    MODE_TICK   = 3'd5,
    MODE_PRUNE  = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    WR_ENTRY = 2'd0,
    WR_CLEAR = 2'd1,
    WR_DL    = 2'd2
  } wr_kind_t;

  // scan item passed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [MAC_W-1:0]  hw;
    logic [PORT_W-1:0] iface;
    logic              empty_found;
    logic [IDX_W-1:0]  empty_idx;
    logic [DL_W-1:0]   min_dl;
    logic [IDX_W-1:0]  min_idx;
    logic [CNT_W-1:0]  prune_cnt;
  } pkt_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic [2:0]        mode;
    logic [KEY_W-1:0]  key;
    logic [DL_W-1:0]   now;
    logic              wr_en;
    wr_kind_t          wr_kind;
    logic [IDX_W-1:0]  wr_idx;
    logic [MAC_W-1:0]  wr_mac;
    logic [PORT_W-1:0] wr_port;
    logic [DL_W-1:0]   wr_dl;
  } cmd_t;

endpackage

[hw/rtl/arpc_cell.sv]
// ----------------------------------------------------------------------------
// arpc_cell
// one table entry plus one stage of the scan chain
// ----------------------------------------------------------------------------
module arpc_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [arpc_pkg::IDX_W-1:0]  cell_idx,
  input  arpc_pkg::cmd_t              cmd,
  input  arpc_pkg::pkt_t              pin,
  output arpc_pkg::pkt_t              pout
);

  logic [arpc_pkg::KEY_W-1:0]  key_r;
  logic [arpc_pkg::MAC_W-1:0]  mac_r;
  logic [arpc_pkg::PORT_W-1:0] port_r;
  logic [arpc_pkg::DL_W-1:0]   dl_r;
  arpc_pkg::pkt_t              pout_r, pout_nxt;
  logic hit_here, empty_here, min_here, prune_here, wr_here;

  assign hit_here   = pin.valid && !pin.hit && (key_r != '0) && (key_r == cmd.key);
  assign empty_here = pin.valid && !pin.empty_found && (key_r == '0);
  assign min_here   = pin.valid && (dl_r < pin.min_dl);
  assign prune_here = pin.valid && (cmd.mode == arpc_pkg::MODE_PRUNE) && (key_r != '0)
                      && (dl_r != '0) && (dl_r <= cmd.now);
  assign wr_here    = cmd.wr_en && (cmd.wr_idx == cell_idx);

  always_comb begin
    pout_nxt = pin;
    if (hit_here) begin
      pout_nxt.hit     = 1'b1;
      pout_nxt.hit_idx = cell_idx;
      pout_nxt.hw      = mac_r;
      pout_nxt.iface   = port_r;
    end
    if (empty_here) begin
      pout_nxt.empty_found = 1'b1;
      pout_nxt.empty_idx   = cell_idx;
    end
    if (min_here) begin
      pout_nxt.min_dl  = dl_r;
      pout_nxt.min_idx = cell_idx;
    end
    pout_nxt.prune_cnt = pin.prune_cnt + arpc_pkg::CNT_W'(prune_here);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= '0;
      mac_r  <= '0;
      port_r <= '0;
      dl_r   <= '0;
      pout_r <= '0;
    end else begin
      pout_r <= pout_nxt;
      if (prune_here) begin
        key_r  <= '0;
        mac_r  <= '0;
        port_r <= '0;
        dl_r   <= '0;
      end else if (wr_here) begin
        case (cmd.wr_kind)
          arpc_pkg::WR_ENTRY: begin
            key_r  <= cmd.key;
            mac_r  <= cmd.wr_mac;
            port_r <= cmd.wr_port;
            dl_r   <= cmd.wr_dl;
          end
          arpc_pkg::WR_CLEAR: begin
            key_r  <= '0;
            mac_r  <= '0;
            port_r <= '0;
            dl_r   <= '0;
          end
          arpc_pkg::WR_DL: dl_r <= cmd.wr_dl;
          default: ;
        endcase
      end
    end
  end

  assign pout = pout_r;

endmodule

[hw/rtl/arp_cache_table.sv]
// ----------------------------------------------------------------------------
// arp_cache_table
// ipv4 to ethernet address cache built as a chain of entry cells
// ----------------------------------------------------------------------------
// result path: an accepted item is registered in launch_r, then walks the cell chain
//   one cell per cycle, is captured in fin_r and is then registered at the outputs
// items: a new item is taken only once the previous result has been registered
// reset: synchronous active-low, clears every entry, time and max_age
// to 1200000; no clearing pass needed
module arp_cache_table #(
  parameter int ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_ip_addr,
  input  logic [47:0] in_hw_addr_in,
  input  logic [3:0]  in_iface_in,
  input  logic [31:0] in_expiry_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic [47:0] out_hw_addr_out,
  output logic [3:0]  out_iface_out,
  output logic [5:0]  out_slot,
  output logic        out_evicted,
  output logic [6:0]  out_pruned_count
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t         state_r, state_nxt;
  logic           launch_r;
  logic [2:0]     mode_r;
  logic [31:0]    key_r, exp_r, now_r, max_age_r;
  logic [47:0]    mac_r;
  logic [3:0]     port_r;
  arpc_pkg::pkt_t fin_r;
  arpc_pkg::pkt_t pkt [ENTRIES+1];
  arpc_pkg::cmd_t cmd;
  logic           in_acc, finish;
  logic [32:0]    dl_sum;
  logic [31:0]    fresh_dl;

  logic        out_valid_r, found_r, evicted_r;
  logic [47:0] hw_r;
  logic [3:0]  iface_r;
  logic [5:0]  slot_r;
  logic [6:0]  pruned_r;

  logic        found_nxt, evicted_nxt;
  logic [47:0] hw_nxt;
  logic [3:0]  iface_nxt;
  logic [5:0]  slot_nxt;
  logic [6:0]  pruned_nxt;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign finish   = (state_r == ST_DONE) && !(out_valid_r && out_stall);
  assign dl_sum   = {1'b0, now_r} + {1'b0, max_age_r};
  assign fresh_dl = dl_sum[32] ? arpc_pkg::DL_MAX : dl_sum[31:0];

  always_comb begin
    pkt[0]          = '0;
    pkt[0].valid    = launch_r;
    pkt[0].min_dl   = arpc_pkg::DL_MAX;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    arpc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (arpc_pkg::IDX_W'(g)),
      .cmd      (cmd),
      .pin      (pkt[g]),
      .pout     (pkt[g+1])
    );
  end

  // decision made once the scan item leaves the last cell
  always_comb begin
    cmd         = '0;
    cmd.mode    = mode_r;
    cmd.key     = key_r;
    cmd.now     = now_r;
    cmd.wr_mac  = mac_r;
    cmd.wr_port = port_r;
    cmd.wr_dl   = fresh_dl;
    cmd.wr_kind = arpc_pkg::WR_ENTRY;
    if (finish) begin
      unique case (mode_r)
        arpc_pkg::MODE_UPDATE: begin
          cmd.wr_en  = fin_r.hit;
          cmd.wr_idx = fin_r.hit_idx;
        end
        arpc_pkg::MODE_ADD: begin
          cmd.wr_en  = (key_r != '0);
          cmd.wr_idx = fin_r.hit ? fin_r.hit_idx :
                       fin_r.empty_found ? fin_r.empty_idx : fin_r.min_idx;
        end
        arpc_pkg::MODE_REMOVE: begin
          cmd.wr_en   = fin_r.hit;
          cmd.wr_idx  = fin_r.hit_idx;
          cmd.wr_kind = arpc_pkg::WR_CLEAR;
        end
        arpc_pkg::MODE_SETEXP: begin
          cmd.wr_en   = fin_r.hit;
          cmd.wr_idx  = fin_r.hit_idx;
          cmd.wr_kind = arpc_pkg::WR_DL;
          cmd.wr_dl   = exp_r;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_SCAN;
      ST_SCAN: if (pkt[ENTRIES].valid) state_nxt = ST_DONE;
      ST_DONE: if (finish) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    found_nxt   = 1'b0;
    hw_nxt      = '0;
    iface_nxt   = '0;
    slot_nxt    = '0;
    evicted_nxt = 1'b0;
    pruned_nxt  = '0;
    unique case (mode_r)
      arpc_pkg::MODE_LOOKUP: if (fin_r.hit) begin
        found_nxt = 1'b1;
        hw_nxt    = fin_r.hw;
        iface_nxt = fin_r.iface;
        slot_nxt  = 6'(fin_r.hit_idx);
      end
      arpc_pkg::MODE_UPDATE, arpc_pkg::MODE_REMOVE, arpc_pkg::MODE_SETEXP:
        if (fin_r.hit) begin
          found_nxt = 1'b1;
          slot_nxt  = 6'(fin_r.hit_idx);
        end
      arpc_pkg::MODE_ADD: if (key_r != '0) begin
        found_nxt   = fin_r.hit;
        evicted_nxt = !fin_r.hit && !fin_r.empty_found;
        slot_nxt    = 6'(cmd.wr_idx);
      end
      arpc_pkg::MODE_PRUNE: pruned_nxt = 7'(fin_r.prune_cnt);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launch_r    <= 1'b0;
      now_r       <= '0;
      max_age_r   <= arpc_pkg::MAX_AGE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= in_acc;
      if (cfg_we) max_age_r <= cfg_wdata;
      if (finish) begin
        out_valid_r <= 1'b1;
        if (mode_r == arpc_pkg::MODE_TICK && now_r != '1) now_r <= now_r + 32'd1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_mode;
      key_r  <= in_ip_addr;
      mac_r  <= in_hw_addr_in;
      port_r <= in_iface_in;
      exp_r  <= in_expiry_value;
    end
    if (pkt[ENTRIES].valid) fin_r <= pkt[ENTRIES];
    if (finish) begin
      found_r   <= found_nxt;
      hw_r      <= hw_nxt;
      iface_r   <= iface_nxt;
      slot_r    <= slot_nxt;
      evicted_r <= evicted_nxt;
      pruned_r  <= pruned_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = found_r;
  assign out_hw_addr_out  = hw_r;
  assign out_iface_out    = iface_r;
  assign out_slot         = slot_r;
  assign out_evicted      = evicted_r;
  assign out_pruned_count = pruned_r;

  // scan item only runs while scanning
  a_launch_scan: assert property (@(posedge clk) disable iff (!rst_n)
    launch_r |-> state_r == ST_SCAN) else $error("scan launched outside scan");
  a_chain_end: assert property (@(posedge clk) disable iff (!rst_n)
    pkt[ENTRIES].valid |-> state_r == ST_SCAN) else $error("stray scan item");
  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_valid_r && state_r == ST_IDLE) else $error("result not shown");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the arp cache table against an in-bench table model with random
// operations, random idling on both channels and several max_age settings
// ----------------------------------------------------------------------------
module tb;

  localparam int NSLOT = 64;
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  typedef struct {
    bit        found;
    bit [47:0] hw;
    bit [3:0]  ifc;
    bit [5:0]  slot;
    bit        ev;
    bit [6:0]  pruned;
  } arp_result_t;

  class arp_scoreboard;
    bit [31:0]   keys[NSLOT];
    bit [47:0]   macs[NSLOT];
    bit [3:0]    ports[NSLOT];
    bit [31:0]   deadlines[NSLOT];
    bit [31:0]   now_time;
    bit [31:0]   max_age;
    arp_result_t pending_q[$];
    int          errors;
    int          n_checked;
    int          n_evict;
    int          n_pruned;

    function new();
      foreach (keys[i]) begin
        keys[i] = 0; macs[i] = 0; ports[i] = 0; deadlines[i] = 0;
      end
      now_time = 0;
      max_age = arpc_pkg::MAX_AGE_RST;
    endfunction

    function int find_slot(bit [31:0] ip);
      if (ip == 0) return -1;
      for (int i = 0; i < NSLOT; i++) if (keys[i] == ip) return i;
      return -1;
    endfunction

    function bit [31:0] fresh_deadline();
      bit [32:0] t;
      t = {1'b0, now_time} + {1'b0, max_age};
      return t[32] ? 32'hFFFF_FFFF : t[31:0];
    endfunction

    function void store(int s, bit [31:0] ip, bit [47:0] mac, bit [3:0] port);
      keys[s] = ip; macs[s] = mac; ports[s] = port;
      deadlines[s] = fresh_deadline();
    endfunction

    function void wipe(int s);
      keys[s] = 0; macs[s] = 0; ports[s] = 0; deadlines[s] = 0;
    endfunction

    function void note_item(bit [2:0] mode, bit [31:0] ip, bit [47:0] mac,
                            bit [3:0] port, bit [31:0] expv);
      arp_result_t r;
      int s;
      r = '{default: 0};
      case (mode)
        arpc_pkg::MODE_LOOKUP: begin
          s = find_slot(ip);
          if (s >= 0) begin
            r.found = 1; r.hw = macs[s]; r.ifc = ports[s]; r.slot = 6'(s);
          end
        end
        arpc_pkg::MODE_UPDATE: begin
          s = find_slot(ip);
          if (s >= 0) begin
            store(s, ip, mac, port); r.found = 1; r.slot = 6'(s);
          end
        end
        arpc_pkg::MODE_ADD: begin
          if (ip != 0) begin
            s = find_slot(ip);
            if (s >= 0) r.found = 1;
            else begin
              for (int i = 0; i < NSLOT; i++)
                if (s < 0 && keys[i] == 0) s = i;
              if (s < 0) begin
                // table full: oldest deadline goes, lowest slot on ties
                s = 0;
                for (int i = 1; i < NSLOT; i++)
                  if (deadlines[i] < deadlines[s]) s = i;
                r.ev = 1;
                n_evict++;
              end
            end
            store(s, ip, mac, port);
            r.slot = 6'(s);
          end
        end
        arpc_pkg::MODE_REMOVE: begin
          s = find_slot(ip);
          if (s >= 0) begin
            wipe(s); r.found = 1; r.slot = 6'(s);
          end
        end
        arpc_pkg::MODE_SETEXP: begin
          s = find_slot(ip);
          if (s >= 0) begin
            deadlines[s] = expv; r.found = 1; r.slot = 6'(s);
          end
        end
        arpc_pkg::MODE_TICK: if (now_time != 32'hFFFF_FFFF) now_time++;
        arpc_pkg::MODE_PRUNE: begin
          for (int i = 0; i < NSLOT; i++)
            if (keys[i] != 0 && deadlines[i] != 0 && deadlines[i] <= now_time) begin
              wipe(i);
              r.pruned++;
            end
          n_pruned += r.pruned;
        end
        default: ;
      endcase
      pending_q.push_back(r);
    endfunction

    function void check_result(arp_result_t got);
      arp_result_t e;
      if (pending_q.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      n_checked++;
      if (got.found != e.found) begin
        $error("found: expected %0d got %0d", e.found, got.found); errors++;
      end
      if (got.hw != e.hw) begin
        $error("hw_addr_out: expected %h got %h", e.hw, got.hw); errors++;
      end
      if (got.ifc != e.ifc) begin
        $error("iface_out: expected %0d got %0d", e.ifc, got.ifc); errors++;
      end
      if (got.slot != e.slot) begin
        $error("slot: expected %0d got %0d", e.slot, got.slot); errors++;
      end
      if (got.ev != e.ev) begin
        $error("evicted: expected %0d got %0d", e.ev, got.ev); errors++;
      end
      if (got.pruned != e.pruned) begin
        $error("pruned_count: expected %0d got %0d", e.pruned, got.pruned); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_mode;
  logic [31:0] in_ip_addr;
  logic [47:0] in_hw_addr_in;
  logic [3:0]  in_iface_in;
  logic [31:0] in_expiry_value;
  logic        out_valid;
  logic        out_stall;
  logic        out_found;
  logic [47:0] out_hw_addr_out;
  logic [3:0]  out_iface_out;
  logic [5:0]  out_slot;
  logic        out_evicted;
  logic [6:0]  out_pruned_count;

  arp_cache_table #(.ENTRIES(NSLOT)) dut (.*);

  arp_scoreboard sb;
  bit [31:0]     ip_pool[80];
  bit            quiet;
  bit            hold_req;
  int            n_sent;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  task automatic send_item(bit [2:0] mode, bit [31:0] ip, bit [47:0] mac,
                           bit [3:0] port, bit [31:0] expv);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_mode <= mode; in_ip_addr <= ip; in_hw_addr_in <= mac;
    in_iface_in <= port; in_expiry_value <= expv;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_item(mode, ip, mac, port, expv);
    n_sent++;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // waits for the table to drain, then writes max_age
  task automatic set_max_age(bit [31:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (NSLOT + 6) @(negedge clk);
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.max_age = v;
  endtask

  function automatic bit [31:0] pick_ip();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 12) return $urandom;
    return ip_pool[$urandom_range(0, 79)];
  endfunction

  task automatic random_item();
    int        r;
    bit [2:0]  mode;
    bit [31:0] expv;
    r = $urandom_range(0, 99);
    if (r < 30)      mode = arpc_pkg::MODE_ADD;
    else if (r < 50) mode = arpc_pkg::MODE_LOOKUP;
    else if (r < 60) mode = arpc_pkg::MODE_UPDATE;
    else if (r < 68) mode = arpc_pkg::MODE_REMOVE;
    else if (r < 77) mode = arpc_pkg::MODE_SETEXP;
    else if (r < 90) mode = arpc_pkg::MODE_TICK;
    else if (r < 98) mode = arpc_pkg::MODE_PRUNE;
    else             mode = MODE_UNUSED;
    r = $urandom_range(0, 9);
    if (r < 2)      expv = 0;
    else if (r < 6) expv = sb.now_time + $urandom_range(0, 4);
    else            expv = $urandom;
    send_item(mode, pick_ip(), 48'({$urandom, $urandom}), 4'($urandom), expv);
  endtask

  // result side: random stall before each item, one long hold on request
  initial begin
    arp_result_t got;
    int r;
    out_stall = 1'b0;
    forever begin
      r = quiet ? 0 : $urandom_range(0, 7);
      if (hold_req) begin
        r = 400;
        hold_req = 0;
      end
      if (r > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (r - 1) @(negedge clk);
        @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      got.found = out_found; got.hw = out_hw_addr_out; got.ifc = out_iface_out;
      got.slot = out_slot; got.ev = out_evicted; got.pruned = out_pruned_count;
      sb.check_result(got);
    end
  end

  initial begin
    bit [31:0] ages[5];
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_wdata = '0;
    in_valid = 1'b0; in_mode = '0; in_ip_addr = '0; in_hw_addr_in = '0;
    in_iface_in = '0; in_expiry_value = '0;
    quiet = 0; hold_req = 0; n_sent = 0;
    foreach (ip_pool[i]) begin
      ip_pool[i] = $urandom;
      if (ip_pool[i] == 0) ip_pool[i] = 1;
    end
    ip_pool[0] = 32'hFFFF_FFFF;
    ip_pool[1] = 32'h1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: zero address, extremes, every mode, hits and misses
    send_item(arpc_pkg::MODE_LOOKUP, 0, 0, 0, 0);
    send_item(arpc_pkg::MODE_ADD, 0, '1, 4'hF, 0);
    send_item(arpc_pkg::MODE_UPDATE, 0, '1, 4'hF, 0);
    send_item(arpc_pkg::MODE_ADD, 32'hFFFF_FFFF, '1, 4'hF, 0);
    send_item(arpc_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0);
    send_item(arpc_pkg::MODE_ADD, 32'h1, 48'h0, 4'h0, 0);
    send_item(arpc_pkg::MODE_UPDATE, 32'h1, 48'hA5A5_5A5A_0F0F, 4'h9, 0);
    send_item(arpc_pkg::MODE_LOOKUP, 32'h1, 0, 0, 0);
    send_item(arpc_pkg::MODE_ADD, 32'hFFFF_FFFF, 48'h1234_5678_9ABC, 4'h3, 0);
    send_item(arpc_pkg::MODE_SETEXP, 32'h1, 0, 0, 32'hFFFF_FFFF);
    send_item(arpc_pkg::MODE_SETEXP, 32'h7, 0, 0, 5);
    send_item(arpc_pkg::MODE_UPDATE, 32'h7, '1, 4'h1, 0);
    send_item(arpc_pkg::MODE_REMOVE, 32'h7, 0, 0, 0);
    send_item(arpc_pkg::MODE_REMOVE, 32'h1, 0, 0, 0);
    send_item(arpc_pkg::MODE_LOOKUP, 32'h1, 0, 0, 0);
    send_item(arpc_pkg::MODE_TICK, 0, 0, 0, 0);
    send_item(arpc_pkg::MODE_PRUNE, 0, 0, 0, 0);
    send_item(MODE_UNUSED, 32'hFFFF_FFFF, '1, 4'hF, '1);
    set_max_age(1);
    send_item(arpc_pkg::MODE_ADD, 32'h2, 48'h1, 4'h2, 0);
    send_item(arpc_pkg::MODE_ADD, 32'h3, 48'h2, 4'h4, 0);
    send_item(arpc_pkg::MODE_SETEXP, 32'h3, 0, 0, 0);
    send_item(arpc_pkg::MODE_TICK, 0, 0, 0, 0);
    send_item(arpc_pkg::MODE_TICK, 0, 0, 0, 0);
    send_item(arpc_pkg::MODE_PRUNE, 0, 0, 0, 0);
    send_item(arpc_pkg::MODE_LOOKUP, 32'h3, 0, 0, 0);

    ages[0] = 3;
    ages[1] = 32'hFFFF_FFFF;
    ages[2] = arpc_pkg::MAX_AGE_RST;
    ages[3] = $urandom_range(1, 20);
    ages[4] = 1;
    for (int p = 0; p < 5; p++) begin
      set_max_age(ages[p]);
      for (int k = 0; k < 106; k++) begin
        quiet = (k >= 40 && k < 60);
        if (p == 1 && k == 10) hold_req = 1;
        random_item();
      end
      quiet = 0;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (NSLOT + 10) @(posedge clk);
    $display("%0d items sent, %0d results checked over 7 max_age settings",
             n_sent, sb.n_checked);
    $display("%0d evictions, %0d entries pruned, time reached %0d",
             sb.n_evict, sb.n_pruned, sb.now_time);
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

[arp_cache_table.f]
hw/rtl/arpc_pkg.sv
hw/rtl/arpc_cell.sv
hw/rtl/arp_cache_table.sv
tb/tb.sv
